/* hw/rtl/bhtc_pkg.sv */
// shared types, constants and tables for the header target check
`timescale 1ns / 1ps
package bhtc_pkg;

  localparam int HEADER_WORDS = 10;
  localparam int CNT_W = 4;

  // configuration register indexes
  localparam logic [2:0] REG_POOL = 3'd0;
  localparam logic [2:0] REG_CHIP0 = 3'd1;
  localparam logic [2:0] REG_CHIP1 = 3'd2;
  localparam logic [2:0] REG_CHIP2 = 3'd3;
  localparam logic [2:0] REG_CHIP3 = 3'd4;

  localparam logic [63:0] POOL_RESET = 64'hffff000000000000;
  localparam logic [63:0] CHIP0_RESET = 64'h00000000ffffffff;
  localparam logic [63:0] CHIP_ONES = 64'hffffffffffffffff;

  // verdict codes
  localparam logic [1:0] VERD_NONE = 2'd0;
  localparam logic [1:0] VERD_CHIP = 2'd1;
  localparam logic [1:0] VERD_POOL = 2'd2;
  localparam logic [1:0] VERD_BAD = 2'd3;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  // parameter block: digest length 32, unkeyed, fanout and depth 1
  localparam logic [63:0] PARAM_WORD = 64'h0000000001010020;
  localparam logic [63:0] BYTE_COUNT = 64'(HEADER_WORDS * 8);
  localparam logic [3:0] LAST_ROUND = 4'd11;

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_QA,
    OP_QB,
    OP_QC,
    OP_QD,
    OP_DIAG_IN,
    OP_DIAG_OUT,
    OP_CMP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic rd_en;
    logic [3:0] rd_addr;
    logic [1:0] cmp_idx;
    logic load_out;
    logic bad;
    logic in_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic good;
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/bhtc_ctrl.sv */
// sequencer for word collection, compression rounds and target compare
`timescale 1ns / 1ps
module bhtc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic word_last,
  input  bhtc_pkg::dp_stat_t stat,
  output bhtc_pkg::dp_cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_INIT  = 11'b00000000010,
    ST_FETCH = 11'b00000000100,
    ST_QA    = 11'b00000001000,
    ST_QB    = 11'b00000010000,
    ST_QC    = 11'b00000100000,
    ST_QD    = 11'b00001000000,
    ST_DIN   = 11'b00010000000,
    ST_DOUT  = 11'b00100000000,
    ST_CMP   = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] g;
  logic diag;
  logic [3:0] round;
  logic [1:0] cidx;
  logic bad;
  logic [3:0] row;
  logic acc;

  assign in_stall = (state != ST_IDLE);
  assign acc = in_valid && !in_stall;
  assign row = (round >= 4'd10) ? (round - 4'd10) : round;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && word_last) state_next = stat.good ? ST_INIT : ST_DONE;
      end
      ST_INIT:  state_next = ST_FETCH;
      ST_FETCH: state_next = ST_QA;
      ST_QA:    state_next = ST_QB;
      ST_QB:    state_next = ST_QC;
      ST_QC:    state_next = ST_QD;
      ST_QD: begin
        if (g == 2'd3) state_next = diag ? ST_DOUT : ST_DIN;
        else state_next = ST_FETCH;
      end
      ST_DIN:   state_next = ST_FETCH;
      ST_DOUT:  state_next = (round == bhtc_pkg::LAST_ROUND) ? ST_CMP : ST_FETCH;
      ST_CMP:   state_next = (cidx == 2'd3) ? ST_DONE : ST_CMP;
      ST_DONE:  state_next = stat.out_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      g <= 2'd0;
      diag <= 1'b0;
      round <= 4'd0;
      cidx <= 2'd0;
      bad <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (acc && word_last) bad <= !stat.good;
        end
        ST_INIT: begin
          g <= 2'd0;
          diag <= 1'b0;
          round <= 4'd0;
          cidx <= 2'd0;
        end
        ST_QD: begin
          g <= g + 2'd1;
          if (g == 2'd3 && !diag) diag <= 1'b1;
        end
        ST_DOUT: begin
          diag <= 1'b0;
          round <= round + 4'd1;
        end
        ST_CMP:  cidx <= cidx + 2'd1;
        default: ;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd = '0;
    cmd.op = bhtc_pkg::OP_NONE;
    cmd.in_acc = acc;
    cmd.cmp_idx = cidx;
    cmd.bad = bad;
    case (state)
      ST_INIT: cmd.op = bhtc_pkg::OP_INIT;
      ST_FETCH: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = bhtc_pkg::SIGMA[row][{diag, g, 1'b0}];
      end
      ST_QA: cmd.op = bhtc_pkg::OP_QA;
      ST_QB: begin
        cmd.op = bhtc_pkg::OP_QB;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = bhtc_pkg::SIGMA[row][{diag, g, 1'b1}];
      end
      ST_QC:   cmd.op = bhtc_pkg::OP_QC;
      ST_QD:   cmd.op = bhtc_pkg::OP_QD;
      ST_DIN:  cmd.op = bhtc_pkg::OP_DIAG_IN;
      ST_DOUT: cmd.op = bhtc_pkg::OP_DIAG_OUT;
      ST_CMP:  cmd.op = bhtc_pkg::OP_CMP;
      ST_DONE: cmd.load_out = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/bhtc_dp.sv */
// message store, compression vector, target compare and result register
`timescale 1ns / 1ps
module bhtc_dp (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] header_word,
  input  logic word_last,
  input  bhtc_pkg::dp_cmd_t cmd,
  output bhtc_pkg::dp_stat_t stat,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] verdict
);

  logic [63:0] pool_target;
  logic [63:0] chip_target [4];
  logic [63:0] mstore [bhtc_pkg::HEADER_WORDS];
  logic [bhtc_pkg::CNT_W-1:0] count;
  logic overflow;
  logic [63:0] mdata;
  logic mzero;
  logic [63:0] mword;
  logic [63:0] v [16];
  logic [63:0] a_sum, d_new, c_sum, b_new;
  logic [63:0] u [16];
  logic [63:0] dig, pool_chunk, chip_chunk, h0;
  logic pool_dec, pool_lt, chip_dec, chip_lt;
  logic [1:0] result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_target <= bhtc_pkg::POOL_RESET;
      chip_target[0] <= bhtc_pkg::CHIP0_RESET;
      chip_target[1] <= bhtc_pkg::CHIP_ONES;
      chip_target[2] <= bhtc_pkg::CHIP_ONES;
      chip_target[3] <= bhtc_pkg::CHIP_ONES;
    end else if (cfg_write) begin
      case (cfg_index)
        bhtc_pkg::REG_POOL:  pool_target <= cfg_data;
        bhtc_pkg::REG_CHIP0: chip_target[0] <= cfg_data;
        bhtc_pkg::REG_CHIP1: chip_target[1] <= cfg_data;
        bhtc_pkg::REG_CHIP2: chip_target[2] <= cfg_data;
        bhtc_pkg::REG_CHIP3: chip_target[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // word count and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      overflow <= 1'b0;
    end else if (cmd.in_acc) begin
      if (word_last) begin
        count <= '0;
        overflow <= 1'b0;
      end else if (count < bhtc_pkg::CNT_W'(bhtc_pkg::HEADER_WORDS)) begin
        count <= count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  assign stat.good = !overflow &&
                     (count == bhtc_pkg::CNT_W'(bhtc_pkg::HEADER_WORDS - 1));

  // message store, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.in_acc && count < bhtc_pkg::CNT_W'(bhtc_pkg::HEADER_WORDS))
      mstore[count] <= header_word;
    if (cmd.rd_en) begin
      mzero <= (cmd.rd_addr >= 4'(bhtc_pkg::HEADER_WORDS));
      if (cmd.rd_addr < 4'(bhtc_pkg::HEADER_WORDS)) mdata <= mstore[cmd.rd_addr];
    end
  end

  assign mword = mzero ? 64'd0 : mdata;

  // quarter steps of the mixing function on the fixed column 0, 4, 8, 12
  always_comb begin
    a_sum = v[0] + v[4] + mword;
    d_new = v[12] ^ a_sum;
    c_sum = v[8] + v[12];
    b_new = v[4] ^ c_sum;
    for (int i = 0; i < 16; i++) u[i] = v[i];
    u[8] = c_sum;
    u[4] = {b_new[62:0], b_new[63]};
  end

  // working vector
  always_ff @(posedge clk) begin
    case (cmd.op)
      bhtc_pkg::OP_INIT: begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= (i == 0) ? (bhtc_pkg::IV[0] ^ bhtc_pkg::PARAM_WORD) : bhtc_pkg::IV[i];
          v[i + 8] <= (i == 4) ? (bhtc_pkg::IV[4] ^ bhtc_pkg::BYTE_COUNT) :
                      (i == 6) ? ~bhtc_pkg::IV[6] : bhtc_pkg::IV[i];
        end
      end
      bhtc_pkg::OP_QA: begin
        v[0] <= a_sum;
        v[12] <= {d_new[31:0], d_new[63:32]};
      end
      bhtc_pkg::OP_QB: begin
        v[8] <= c_sum;
        v[4] <= {b_new[23:0], b_new[63:24]};
      end
      bhtc_pkg::OP_QC: begin
        v[0] <= a_sum;
        v[12] <= {d_new[15:0], d_new[63:16]};
      end
      bhtc_pkg::OP_QD: begin
        // finish and move the next column under the fixed positions
        for (int r = 0; r < 4; r++)
          for (int j = 0; j < 4; j++)
            v[4 * r + j] <= u[4 * r + ((j + 1) % 4)];
      end
      bhtc_pkg::OP_DIAG_IN: begin
        for (int r = 0; r < 4; r++)
          for (int j = 0; j < 4; j++)
            v[4 * r + j] <= v[4 * r + ((j + r) % 4)];
      end
      bhtc_pkg::OP_DIAG_OUT: begin
        for (int r = 0; r < 4; r++)
          for (int j = 0; j < 4; j++)
            v[4 * r + j] <= v[4 * r + ((j + 4 - r) % 4)];
      end
      default: ;
    endcase
  end

  // digest word and target chunks, most significant chunk first
  always_comb begin
    h0 = bhtc_pkg::IV[{1'b0, cmd.cmp_idx}];
    if (cmd.cmp_idx == 2'd0) h0 = h0 ^ bhtc_pkg::PARAM_WORD;
    dig = h0 ^ v[{2'b00, cmd.cmp_idx}] ^ v[{2'b10, cmd.cmp_idx}];
    dig = {<<8{dig}};
    case (cmd.cmp_idx)
      2'd0:    pool_chunk = {32'd0, pool_target[63:32]};
      2'd1:    pool_chunk = {pool_target[31:0], 32'hffffffff};
      default: pool_chunk = bhtc_pkg::CHIP_ONES;
    endcase
    chip_chunk = chip_target[cmd.cmp_idx];
  end

  // compare flags
  always_ff @(posedge clk) begin
    if (cmd.op == bhtc_pkg::OP_INIT) begin
      pool_dec <= 1'b0;
      pool_lt <= 1'b0;
      chip_dec <= 1'b0;
      chip_lt <= 1'b0;
    end else if (cmd.op == bhtc_pkg::OP_CMP) begin
      if (!pool_dec && dig != pool_chunk) begin
        pool_dec <= 1'b1;
        pool_lt <= dig < pool_chunk;
      end
      if (!chip_dec && dig != chip_chunk) begin
        chip_dec <= 1'b1;
        chip_lt <= dig < chip_chunk;
      end
    end
  end

  always_comb begin
    if (cmd.bad) result = bhtc_pkg::VERD_BAD;
    else if (pool_dec && pool_lt) result = bhtc_pkg::VERD_POOL;
    else if (!chip_dec || chip_lt) result = bhtc_pkg::VERD_CHIP;
    else result = bhtc_pkg::VERD_NONE;
  end

  // result register
  assign stat.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) verdict <= result;
  end

endmodule

/* hw/rtl/blake2b_header_target_check_core.sv */
// header hash and target check: top level
// a header is taken one word per cycle while in_stall is low; a full header then runs
// an init step, twelve rounds of fetch, quarter mixing and diagonal steps, and the compare
// a bad word count skips the rounds and goes straight to loading its result
// the input stays closed from the last word of a header until its verdict is loaded
// synchronous reset restores the target registers and clears counts and the result valid flag
`timescale 1ns / 1ps
module blake2b_header_target_check_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [63:0] header_word,
  input  logic word_last,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] verdict
);

  bhtc_pkg::dp_cmd_t cmd;
  bhtc_pkg::dp_stat_t stat;

  // controller
  bhtc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .word_last(word_last),
    .stat(stat),
    .cmd(cmd)
  );

  // datapath
  bhtc_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .header_word(header_word),
    .word_last(word_last),
    .cmd(cmd),
    .stat(stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict)
  );

  // last word of a request closes the input until the verdict is loaded
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && word_last |=> in_stall)
    else $error("input open after last word");

  // a new result appears only by a load from the controller
  a_load_only: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(cmd.load_out))
    else $error("result without load");

  // a load never overwrites a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result overwritten");

endmodule

/* verif/tb_blake2b_header_target_check_core.sv */
// testbench for the header hash and target check core
`timescale 1ns / 1ps
module tb_blake2b_header_target_check_core;

  typedef logic [63:0] words_t [bhtc_pkg::HEADER_WORDS];

  typedef struct {
    logic [63:0] word;
    logic        last;
  } request_t;

  // lanes of the eight mixing steps within one round
  localparam int LANE_A [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
  localparam int LANE_B [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
  localparam int LANE_C [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
  localparam int LANE_D [8] = '{12, 13, 14, 15, 15, 12, 13, 14};
  localparam int SETTLE_CYCLES = 600;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [63:0] header_word;
  logic word_last;
  logic out_valid;
  logic out_stall;
  logic [1:0] verdict;

  request_t request_q[$];
  logic [1:0] verdict_q[$];
  int error_count = 0;
  int words_sent = 0;

  // predictor state
  logic [63:0] pool_reg;
  logic [63:0] chip_reg [4];
  words_t rx_words;
  int rx_count = 0;
  logic rx_overflow = 1'b0;

  // sender burst control and receiver stall pattern
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_hold = 0;

  blake2b_header_target_check_core u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .header_word(header_word),
    .word_last(word_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // unkeyed 32-byte digest of one header, digest byte 0 in bits 255:248
  function automatic logic [255:0] header_digest(input words_t m);
    logic [63:0] h [8];
    logic [63:0] v [16];
    logic [63:0] mw [16];
    logic [63:0] x;
    logic [63:0] y;
    logic [255:0] dg;
    int a, b, c, d;
    for (int i = 0; i < 16; i++) mw[i] = (i < bhtc_pkg::HEADER_WORDS) ? m[i] : 64'd0;
    for (int i = 0; i < 8; i++) h[i] = bhtc_pkg::IV[i];
    h[0] ^= bhtc_pkg::PARAM_WORD;
    for (int i = 0; i < 8; i++) begin
      v[i] = h[i];
      v[i + 8] = bhtc_pkg::IV[i];
    end
    v[12] ^= bhtc_pkg::BYTE_COUNT;
    v[14] = ~v[14];
    for (int r = 0; r < 12; r++) begin
      for (int j = 0; j < 8; j++) begin
        a = LANE_A[j];
        b = LANE_B[j];
        c = LANE_C[j];
        d = LANE_D[j];
        x = mw[bhtc_pkg::SIGMA[r % 10][2 * j]];
        y = mw[bhtc_pkg::SIGMA[r % 10][2 * j + 1]];
        v[a] = v[a] + v[b] + x;
        v[d] = rotr(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + y;
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 63);
      end
    end
    for (int i = 0; i < 8; i++) h[i] ^= v[i] ^ v[i + 8];
    for (int i = 0; i < 32; i++) dg[255 - 8 * i -: 8] = h[i >> 3][8 * (i & 7) +: 8];
    return dg;
  endfunction

  // byte-wise compare from byte 0 is an unsigned compare of the packed vectors
  function automatic logic [1:0] grade_digest(input logic [255:0] dg);
    logic [255:0] pool_t;
    logic [255:0] chip_t;
    pool_t = {32'd0, pool_reg, {160{1'b1}}};
    chip_t = {chip_reg[0], chip_reg[1], chip_reg[2], chip_reg[3]};
    if (dg < pool_t) return bhtc_pkg::VERD_POOL;
    if (dg <= chip_t) return bhtc_pkg::VERD_CHIP;
    return bhtc_pkg::VERD_NONE;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // predictor: follows every accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (rx_count < bhtc_pkg::HEADER_WORDS) begin
        rx_words[rx_count] = header_word;
        rx_count++;
      end else begin
        rx_overflow = 1'b1;
      end
      if (word_last) begin
        if (rx_overflow || rx_count != bhtc_pkg::HEADER_WORDS)
          verdict_q.push_back(bhtc_pkg::VERD_BAD);
        else verdict_q.push_back(grade_digest(header_digest(rx_words)));
        rx_count = 0;
        rx_overflow = 1'b0;
      end
    end
  end

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      header_word <= 64'd0;
      word_last <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) void'(request_q.pop_front());
      if (gap_left > 0 || request_q.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid <= 1'b1;
        header_word <= request_q[0].word;
        word_last <= request_q[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver stall pattern: none, light or heavy, changing now and then
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_hold = $urandom_range(20, 400);
      end else begin
        stall_hold--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // monitor: compare each verdict with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict %0d", verdict));
      end else if (verdict !== verdict_q[0]) begin
        report_mismatch($sformatf("verdict %0d, expected %0d", verdict, verdict_q[0]));
        void'(verdict_q.pop_front());
      end else begin
        void'(verdict_q.pop_front());
      end
    end
  end

  function automatic logic [63:0] pick_word(input int fill);
    int sel;
    if (fill == 1) return 64'd0;
    if (fill == 2) return '1;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 64'd0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // fill: 0 random words, 1 all zero, 2 all ones
  task automatic queue_header(input int n, input int fill);
    request_t rq;
    for (int i = 0; i < n; i++) begin
      rq.word = pick_word(fill);
      rq.last = (i == n - 1);
      request_q.push_back(rq);
      words_sent++;
    end
  endtask

  task automatic queue_random_headers(input int n_words);
    int stop;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      if ($urandom_range(0, 6) != 0) queue_header(bhtc_pkg::HEADER_WORDS, 0);
      else queue_header($urandom_range(1, 13), 0);
    end
  endtask

  // wait for every request and verdict, then let the rounds settle
  task automatic wait_idle;
    while (request_q.size() != 0 || verdict_q.size() != 0 || in_valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_targets(input logic [63:0] pool, input logic [63:0] c0,
                               input logic [63:0] c1, input logic [63:0] c2,
                               input logic [63:0] c3);
    logic [63:0] vals [5];
    logic [2:0] idx [5];
    vals = '{pool, c0, c1, c2, c3};
    idx = '{bhtc_pkg::REG_POOL, bhtc_pkg::REG_CHIP0, bhtc_pkg::REG_CHIP1,
            bhtc_pkg::REG_CHIP2, bhtc_pkg::REG_CHIP3};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    pool_reg = pool;
    chip_reg = '{c0, c1, c2, c3};
  endtask

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    words_t zero_hdr;
    logic [255:0] zero_dg;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = bhtc_pkg::REG_POOL;
    cfg_data = 64'd0;
    pool_reg = bhtc_pkg::POOL_RESET;
    chip_reg = '{bhtc_pkg::CHIP0_RESET, bhtc_pkg::CHIP_ONES, bhtc_pkg::CHIP_ONES,
                 bhtc_pkg::CHIP_ONES};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset targets: full header of ones, a lone last word, one word too many
    queue_header(bhtc_pkg::HEADER_WORDS, 2);
    queue_header(1, 0);
    queue_header(bhtc_pkg::HEADER_WORDS + 1, 1);
    wait_idle();

    // all-zero targets then all-ones targets
    write_targets(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    queue_random_headers(60);
    wait_idle();
    write_targets('1, '1, '1, '1, '1);
    queue_random_headers(60);
    wait_idle();

    // digest exactly on the chip target meets it, one below misses
    for (int i = 0; i < bhtc_pkg::HEADER_WORDS; i++) zero_hdr[i] = 64'd0;
    zero_dg = header_digest(zero_hdr);
    write_targets(64'd0, zero_dg[255:192], zero_dg[191:128], zero_dg[127:64], zero_dg[63:0]);
    queue_header(bhtc_pkg::HEADER_WORDS, 1);
    wait_idle();
    zero_dg = zero_dg - 256'd1;
    write_targets(64'd0, zero_dg[255:192], zero_dg[191:128], zero_dg[127:64], zero_dg[63:0]);
    queue_header(bhtc_pkg::HEADER_WORDS, 1);
    wait_idle();

    // random targets so both outcomes can turn up
    for (int p = 0; p < 4; p++) begin
      write_targets({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      queue_random_headers(110);
      wait_idle();
    end

    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bhtc_pkg.sv
hw/rtl/bhtc_ctrl.sv
hw/rtl/bhtc_dp.sv
hw/rtl/blake2b_header_target_check_core.sv
verif/tb_blake2b_header_target_check_core.sv
